/* rtl/assert_macros.svh */
// Assertion helpers shared by the control and datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication form: cond |-> prop.
`define ASSERT_IMP(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

/* rtl/plni_pkg.sv */
package plni_pkg;

    localparam int SITE_W     = 32;
    localparam int SIDE_W     = 9;
    localparam int DIM_W      = 3;
    localparam int DIR_W      = 2;
    localparam int VOL_W      = 34;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = SITE_W / DIV_BITS;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    localparam logic [VOL_W-1:0]  VOL_CAP  = 34'h2_0000_0000;
    localparam logic [SIDE_W-1:0] SIDE_RST = 9'd16;
    localparam logic [DIM_W-1:0]  DIMS_RST = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOL,
        ST_CHK,
        ST_DIV,
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [DIM_W-1:0]  dims;
    } t_cfg;

    typedef struct packed {
        logic             load_site;
        logic             vol_step;
        logic             div_clr;
        logic             div_step;
        logic             load_out;
        logic             load_err;
        logic             last;
        logic [DIR_W-1:0] dir;
    } t_cmd;

    typedef struct packed {
        logic site_err;
    } t_stat;

endpackage

/* rtl/plni_cfg.sv */
module plni_cfg import plni_pkg::*; #(
    parameter int MAX_DIM  = 4,
    parameter int MAX_SIDE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [SIDE_W-1:0] r_side;
    logic [DIM_W-1:0]  r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RST;
            r_dims <= DIMS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIDE: r_side <= i_cfg_data;
                REG_DIMS: r_dims <= i_cfg_data[DIM_W-1:0];
                default:  ;
            endcase
        end
    end

    // zero acts as one, oversize values clamp to the build limits
    always_comb begin
        o_cfg.side = r_side;
        if (r_side == '0) begin
            o_cfg.side = SIDE_W'(1);
        end else if (32'(r_side) > 32'(MAX_SIDE)) begin
            o_cfg.side = SIDE_W'(MAX_SIDE);
        end
        o_cfg.dims = r_dims;
        if (r_dims == '0) begin
            o_cfg.dims = DIM_W'(1);
        end else if (32'(r_dims) > 32'(MAX_DIM)) begin
            o_cfg.dims = DIM_W'(MAX_DIM);
        end
    end

endmodule

/* rtl/plni_ctrl.sv */
module plni_ctrl import plni_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

`include "assert_macros.svh"

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_dim, n_dim;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_fin, n_fin;
    logic               dim_last;

    assign dim_last = (r_dim == i_cfg.dims - DIM_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dim   <= '0;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_cnt       = r_cnt;
        n_fin       = r_fin;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_site = 1'b1;
                    n_dim           = '0;
                    n_state         = ST_VOL;
                end
            end
            ST_VOL: begin
                o_cmd.vol_step = 1'b1;
                if (dim_last) begin
                    n_dim   = '0;
                    n_state = ST_CHK;
                end else begin
                    n_dim = r_dim + DIM_W'(1);
                end
            end
            ST_CHK: begin
                if (i_stat.site_err) begin
                    o_cmd.load_err = 1'b1;
                    n_fin          = 1'b1;
                    n_state        = ST_EMIT;
                end else begin
                    o_cmd.div_clr = 1'b1;
                    n_cnt         = '0;
                    n_state       = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_out = 1'b1;
                o_cmd.last     = dim_last;
                o_cmd.dir      = r_dim[DIR_W-1:0];
                n_fin          = dim_last;
                n_state        = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_fin) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.div_clr = 1'b1;
                        n_dim         = r_dim + DIM_W'(1);
                        n_cnt         = '0;
                        n_state       = ST_DIV;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_in_out_excl, !(o_in_ready && o_out_valid), "input and output open together")
    `ASSERT_IMP(a_dim_range, r_state == ST_DIV, r_dim < i_cfg.dims, "direction past dimension count")
    `ASSERT_IMP(a_emit_after_work, $rose(o_out_valid),
        $past(r_state) == ST_LOAD || $past(r_state) == ST_CHK, "result without load")

endmodule

/* rtl/plni_dp.sv */
module plni_dp import plni_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic [SITE_W-1:0] i_site,
    output t_stat             o_stat,
    output logic [DIR_W-1:0]  o_direction,
    output logic [SITE_W-1:0] o_forward_neighbor,
    output logic [SITE_W-1:0] o_backward_neighbor,
    output logic              o_last,
    output logic              o_site_error
);

`include "assert_macros.svh"

    logic [SITE_W-1:0] r_site;
    logic [SITE_W-1:0] r_quo;
    logic [SIDE_W-1:0] r_rem;
    logic [VOL_W-1:0]  r_vol;
    logic [SITE_W-1:0] r_stride;
    logic [SITE_W-1:0] r_prod;
    logic [DIR_W-1:0]  r_dir;
    logic [SITE_W-1:0] r_fwd;
    logic [SITE_W-1:0] r_bwd;
    logic              r_last;
    logic              r_err;

    logic [VOL_W+SIDE_W-1:0]  vol_mul;
    logic [VOL_W-1:0]         n_vol;
    logic [SITE_W+SIDE_W-1:0] prod_mul;
    logic [SITE_W-1:0]        n_quo;
    logic [SIDE_W-1:0]        n_rem;
    logic [SIDE_W:0]          rem_w;
    logic                     wrap_fwd;
    logic                     wrap_bwd;
    logic [SITE_W-1:0]        fwd;
    logic [SITE_W-1:0]        bwd;

    // running volume, saturated above any 32-bit index
    assign vol_mul = (VOL_W+SIDE_W)'(r_vol) * (VOL_W+SIDE_W)'(i_cfg.side);
    assign n_vol   = (vol_mul > (VOL_W+SIDE_W)'(VOL_CAP)) ? VOL_CAP : vol_mul[VOL_W-1:0];

    assign o_stat.site_err = ((VOL_W)'(r_site) >= r_vol);

    // (L-1)*stride: distance of a wrap along the current direction
    assign prod_mul = (SITE_W+SIDE_W)'(i_cfg.side - SIDE_W'(1)) *
                      (SITE_W+SIDE_W)'(r_stride);

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        n_quo = r_quo;
        rem_w = {1'b0, r_rem};
        for (int k = 0; k < DIV_BITS; k++) begin
            rem_w = {rem_w[SIDE_W-1:0], n_quo[SITE_W-1]};
            n_quo = {n_quo[SITE_W-2:0], 1'b0};
            if (rem_w >= {1'b0, i_cfg.side}) begin
                rem_w    = rem_w - {1'b0, i_cfg.side};
                n_quo[0] = 1'b1;
            end
        end
        n_rem = rem_w[SIDE_W-1:0];
    end

    // r_rem is the coordinate once the division is done
    assign wrap_fwd = ({1'b0, r_rem} + (SIDE_W+1)'(1) >= {1'b0, i_cfg.side});
    assign wrap_bwd = (r_rem == '0);
    assign fwd      = wrap_fwd ? r_site - r_prod : r_site + r_stride;
    assign bwd      = wrap_bwd ? r_site + r_prod : r_site - r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.div_clr) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_site) begin
            r_site   <= i_site;
            r_quo    <= i_site;
            r_vol    <= VOL_W'(1);
            r_stride <= SITE_W'(1);
        end else begin
            if (i_cmd.vol_step) begin
                r_vol <= n_vol;
            end
            if (i_cmd.div_step) begin
                r_quo  <= n_quo;
                r_prod <= prod_mul[SITE_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_stride <= r_stride + r_prod;
            end
        end
        if (i_cmd.load_out) begin
            r_dir  <= i_cmd.dir;
            r_fwd  <= fwd;
            r_bwd  <= bwd;
            r_last <= i_cmd.last;
            r_err  <= 1'b0;
        end else if (i_cmd.load_err) begin
            r_dir  <= '0;
            r_fwd  <= '0;
            r_bwd  <= '0;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end
    end

    assign o_direction         = r_dir;
    assign o_forward_neighbor  = r_fwd;
    assign o_backward_neighbor = r_bwd;
    assign o_last              = r_last;
    assign o_site_error        = r_err;

    `ASSERT_IMP(a_rem_below_side, i_cmd.div_step, r_rem < i_cfg.side, "remainder not below side")

endmodule

/* rtl/periodic_lattice_neighbor_index.sv */
// Nearest-neighbor index generator for a periodic hypercubic lattice.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = side L, 1 = dimension count D) with no wait; write only while idle.
// Input channel i_valid/o_ready carries one site index per word.
// Output channel o_valid/i_ready carries D words per site, direction 0
// first, with forward and backward neighbor indices; o_last marks the
// final word. A site at or beyond L^D yields one word with o_site_error
// and o_last set and zero neighbors.
// One site is handled at a time: a new site is taken only once the last
// word of the previous one has been taken. The cost is set by the volume
// product over the dimensions and the shared radix-16 divider for each
// dimension, plus a load and an output step per direction.
// A result stays on the outputs until taken; a stalled receiver holds the
// block in place. Reset sets L = 16, D = 3 and returns to idle.
module periodic_lattice_neighbor_index import plni_pkg::*; #(
    parameter int MAX_DIM  = 4,
    parameter int MAX_SIDE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SITE_W-1:0]    i_site,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DIR_W-1:0]     o_direction,
    output logic [SITE_W-1:0]    o_forward_neighbor,
    output logic [SITE_W-1:0]    o_backward_neighbor,
    output logic                 o_last,
    output logic                 o_site_error
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    plni_cfg #(
        .MAX_DIM  (MAX_DIM),
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    plni_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    plni_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .i_site              (i_site),
        .o_stat              (stat),
        .o_direction         (o_direction),
        .o_forward_neighbor  (o_forward_neighbor),
        .o_backward_neighbor (o_backward_neighbor),
        .o_last              (o_last),
        .o_site_error        (o_site_error)
    );

endmodule

/* bench/plni_checker.sv */
module plni_checker import plni_pkg::*; #(
    parameter int MAX_DIM  = 4,
    parameter int MAX_SIDE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [SITE_W-1:0]    i_site,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [DIR_W-1:0]     i_direction,
    input  logic [SITE_W-1:0]    i_forward_neighbor,
    input  logic [SITE_W-1:0]    i_backward_neighbor,
    input  logic                 i_last,
    input  logic                 i_site_error,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIR_W-1:0]  dir;
        logic [SITE_W-1:0] fwd;
        logic [SITE_W-1:0] bwd;
        logic              last;
        logic              err;
    } t_nbr_word;

    t_nbr_word         nbr_q[$];
    logic [SIDE_W-1:0] cfg_side = SIDE_RST;
    logic [DIM_W-1:0]  cfg_dims = DIMS_RST;
    int                fail_cnt = 0;
    int                pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // Expected neighbor words for one site under the current lattice setup.
    function automatic void predict_neighbors(input logic [SITE_W-1:0] s);
        longint unsigned side, dims, vol, rest, stride, x, xp, xm, base;
        longint unsigned d;
        t_nbr_word w;
        side = 64'(cfg_side);
        if (side == 0) side = 1;
        if (side > 64'(MAX_SIDE)) side = 64'(MAX_SIDE);
        dims = 64'(cfg_dims);
        if (dims == 0) dims = 1;
        if (dims > 64'(MAX_DIM)) dims = 64'(MAX_DIM);
        vol = 1;
        for (d = 0; d < dims; d++) begin
            vol = vol * side;
            if (vol > 64'(VOL_CAP)) vol = 64'(VOL_CAP);
        end
        if (64'(s) >= vol) begin
            w = '{dir: '0, fwd: '0, bwd: '0, last: 1'b1, err: 1'b1};
            nbr_q.push_back(w);
        end else begin
            rest   = 64'(s);
            stride = 1;
            for (d = 0; d < dims; d++) begin
                x    = rest % side;
                xp   = (x + 1 >= side) ? x + 1 - side : x + 1;
                xm   = (x == 0) ? side - 1 : x - 1;
                base = 64'(s) - x * stride;
                rest = rest / side;
                w.dir  = d[DIR_W-1:0];
                w.fwd  = SITE_W'(base + xp * stride);
                w.bwd  = SITE_W'(base + xm * stride);
                w.last = (d + 1 == dims);
                w.err  = 1'b0;
                nbr_q.push_back(w);
                stride = stride * side;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_nbr_word w;
        if (!i_rst_n) begin
            cfg_side = SIDE_RST;
            cfg_dims = DIMS_RST;
            nbr_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_neighbors(i_site);
            if (i_out_valid && i_out_ready) begin
                if (nbr_q.size() == 0) begin
                    report_mismatch($sformatf("word with no site pending (dir %0d fwd %0h)",
                                              i_direction, i_forward_neighbor));
                end else begin
                    w = nbr_q.pop_front();
                    if (i_direction !== w.dir)
                        report_mismatch($sformatf("direction got %0d want %0d",
                                                  i_direction, w.dir));
                    if (i_forward_neighbor !== w.fwd)
                        report_mismatch($sformatf("forward got %0h want %0h",
                                                  i_forward_neighbor, w.fwd));
                    if (i_backward_neighbor !== w.bwd)
                        report_mismatch($sformatf("backward got %0h want %0h",
                                                  i_backward_neighbor, w.bwd));
                    if (i_last !== w.last)
                        report_mismatch($sformatf("last got %0b want %0b", i_last, w.last));
                    if (i_site_error !== w.err)
                        report_mismatch($sformatf("site_error got %0b want %0b",
                                                  i_site_error, w.err));
                end
            end
            // register writes only happen while idle, so order vs. accept is moot
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SIDE) cfg_side = i_cfg_data;
                else if (i_cfg_idx == REG_DIMS) cfg_dims = i_cfg_data[DIM_W-1:0];
            end
        end
        pend_cnt = nbr_q.size();
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    import plni_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM   = 4;
    localparam int MAX_SIDE  = 256;
    localparam int QUIET_CYC = 20;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = REG_SIDE;
    logic [SIDE_W-1:0]    i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [SITE_W-1:0]    i_site      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [DIR_W-1:0]     o_direction;
    logic [SITE_W-1:0]    o_forward_neighbor;
    logic [SITE_W-1:0]    o_backward_neighbor;
    logic                 o_last;
    logic                 o_site_error;

    int fail_count;
    int pending;

    // volume seen by the stimulus side, saturated above the site range
    longint unsigned stim_vol = 4096;

    int rdy_mode = 0;
    int rdy_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    periodic_lattice_neighbor_index #(
        .MAX_DIM (MAX_DIM),
        .MAX_SIDE(MAX_SIDE)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_site             (i_site),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_direction        (o_direction),
        .o_forward_neighbor (o_forward_neighbor),
        .o_backward_neighbor(o_backward_neighbor),
        .o_last             (o_last),
        .o_site_error       (o_site_error)
    );

    plni_checker #(
        .MAX_DIM (MAX_DIM),
        .MAX_SIDE(MAX_SIDE)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_site             (i_site),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_direction        (o_direction),
        .i_forward_neighbor (o_forward_neighbor),
        .i_backward_neighbor(o_backward_neighbor),
        .i_last             (o_last),
        .i_site_error       (o_site_error),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // receiver: stall mode is redrawn at random, mode 0 never stalls
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(4, 60);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 1) == 1);
            2:       i_ready <= ($urandom_range(0, 7) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_site(input logic [SITE_W-1:0] s);
        i_valid <= 1'b1;
        i_site  <= s;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // wait for every neighbor word, then let the block settle back to idle
    task automatic drain;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (QUIET_CYC) @(posedge i_clk);
    endtask

    task automatic set_lattice(input logic [SIDE_W-1:0] side, input logic [DIM_W-1:0] dims);
        longint unsigned es, ed, v;
        logic [SIDE_W-DIM_W-1:0] junk;
        junk = (SIDE_W-DIM_W)'($urandom);
        es = (side == 0) ? 64'(1) : ((side > MAX_SIDE) ? 64'(MAX_SIDE) : 64'(side));
        ed = (dims == 0) ? 64'(1) : ((dims > MAX_DIM) ? 64'(MAX_DIM) : 64'(dims));
        v  = 1;
        repeat (ed) begin
            v = v * es;
            if (v > 64'h2_0000_0000) v = 64'h2_0000_0000;
        end
        stim_vol   = v;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SIDE;
        i_cfg_data <= side;
        @(posedge i_clk);
        // upper bits of the dimension word are don't-care for the block
        i_cfg_idx  <= REG_DIMS;
        i_cfg_data <= {junk, dims};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SITE_W-1:0] pick_site;
        int r;
        r = $urandom_range(0, 9);
        if (r <= 6) begin
            if (stim_vol >= 64'h1_0000_0000) return $urandom;
            return SITE_W'(longint'($urandom) % stim_vol);
        end
        if (r == 7) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return SITE_W'(stim_vol - 1);
                default: return SITE_W'(stim_vol);
            endcase
        end
        if (r == 8) return $urandom;
        return $urandom_range(0, 1) ? '1 : ($urandom | 32'h8000_0000);
    endfunction

    task automatic run_sites(input int n);
        int sent, burst, gap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n; i++) begin
                send_site(pick_site());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0 || sent >= n) begin
                i_valid <= 1'b0;
                repeat (gap + 1) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_list(input logic [SITE_W-1:0] sites[]);
        foreach (sites[k]) send_site(sites[k]);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [SIDE_W-1:0] side;
        logic [DIM_W-1:0]  dims;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lattice 16^3: corners, first out-of-range site, coordinate rollovers
        send_list('{32'd0, 32'd4095, 32'd4096, 32'hFFFF_FFFF, 32'd15, 32'd16,
                    32'd255, 32'd256, 32'd1234});
        drain();
        // side of one: both neighbors are the site itself
        set_lattice(9'd1, 3'd1);
        send_list('{32'd0, 32'd1, 32'hFFFF_FFFF});
        drain();
        // zero side and zero dimensions act as one
        set_lattice(9'd0, 3'd0);
        send_list('{32'd0, 32'd5});
        drain();
        // full 32-bit volume, no out-of-range site exists
        set_lattice(9'd256, 3'd4);
        send_list('{32'd0, 32'hFFFF_FFFF, 32'h8080_8080});
        drain();
        // oversized side and dimension count clamp to the maximum
        set_lattice(9'd511, 3'd7);
        send_list('{32'hFFFF_FFFF, 32'h0102_0304});
        drain();
        set_lattice(9'd2, 3'd4);
        send_list('{32'd15, 32'd16});
        drain();

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 9))
                0:       side = 9'd0;
                1:       side = 9'd1;
                2:       side = 9'd256;
                3:       side = SIDE_W'($urandom_range(257, 511));
                default: side = SIDE_W'($urandom_range(2, 20));
            endcase
            dims = DIM_W'($urandom_range(0, 7));
            set_lattice(side, dims);
            run_sites($urandom_range(18, 32));
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/plni_pkg.sv
rtl/plni_cfg.sv
rtl/plni_ctrl.sv
rtl/plni_dp.sv
rtl/periodic_lattice_neighbor_index.sv
bench/plni_checker.sv
bench/tb_top.sv
